>>> rtl/npsrch_pkg.sv
// Shared constants, types and command/status structs of the nearest point search block.
package npsrch_pkg;

  localparam int POINT_COUNT = 128;
  localparam int IDX_W       = $clog2(POINT_COUNT);
  localparam int SLOT_W      = 7;
  localparam int COORD_W     = 16;
  localparam int PT_W        = 3 * COORD_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = 34;
  localparam int OUT_IDX_W   = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = 34'd12884508675;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  typedef struct packed {
    logic store_we;
    logic query_load;
    logic scan_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
  } dp_status_t;

endpackage

>>> rtl/npsrch_ram.sv
// Generic single write port, single read port RAM with registered read data.
module npsrch_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/npsrch_ctrl.sv
// Controller state machine that sequences stores, table scans and result reporting.
module npsrch_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_opcode,
  input  npsrch_pkg::dp_status_t status,
  output npsrch_pkg::ctrl_cmd_t  cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import npsrch_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.pipe_empty) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.store_we   = accept && (in_opcode == OP_STORE);
    cmd.query_load = accept && (in_opcode == OP_QUERY);
    cmd.scan_run   = (state_r == ST_SCAN);
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_REPORT);

endmodule

>>> rtl/npsrch_dp.sv
// Datapath: point table, valid marks, scan counter and the distance and minimum pipeline.
module npsrch_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  npsrch_pkg::ctrl_cmd_t               cmd,
  input  logic [npsrch_pkg::SLOT_W-1:0]       in_slot,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_z,
  output npsrch_pkg::dp_status_t              status,
  output logic [npsrch_pkg::OUT_IDX_W-1:0]    out_nearest_index,
  output logic [npsrch_pkg::DIST_W-1:0]       out_distance_sq,
  output logic                                out_found
);
  import npsrch_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] n;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  logic [POINT_COUNT-1:0] point_valid_r;
  logic                   wr_en;
  logic [PT_W-1:0]        rd_data;
  logic [IDX_W-1:0]       cnt_r;

  logic [COORD_W-1:0] qx_r, qy_r, qz_r;

  logic               p1_r, p2_r, p3_r, p4_r;
  logic               vld1_r, vld2_r, vld3_r, vld4_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COORD_W-1:0] ax2_r, ay2_r, az2_r;
  logic [SQ_W-1:0]    sx3_r, sy3_r, sz3_r;
  logic [DIST_W-1:0]  sum4_r;

  logic [DIST_W-1:0]  best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               found_r;
  logic               take;

  assign wr_en = cmd.store_we && (int'(in_slot) < POINT_COUNT);

  npsrch_ram #(
    .WIDTH(PT_W),
    .DEPTH(POINT_COUNT)
  ) u_points (
    .clk  (clk),
    .we   (wr_en),
    .waddr(IDX_W'(in_slot)),
    .wdata({in_coord_z, in_coord_y, in_coord_x}),
    .raddr(cnt_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_valid_r <= '0;
      cnt_r         <= '0;
      p1_r          <= 1'b0;
      p2_r          <= 1'b0;
      p3_r          <= 1'b0;
      p4_r          <= 1'b0;
    end else begin
      if (wr_en) begin
        point_valid_r[IDX_W'(in_slot)] <= 1'b1;
      end
      if (cmd.query_load) begin
        cnt_r <= '0;
      end else if (cmd.scan_run) begin
        cnt_r <= cnt_r + 1'b1;
      end
      p1_r <= cmd.scan_run;
      p2_r <= p1_r;
      p3_r <= p2_r;
      p4_r <= p3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      qz_r <= in_coord_z;
    end
    vld1_r <= point_valid_r[cnt_r];
    idx1_r <= cnt_r;

    vld2_r <= vld1_r;
    idx2_r <= idx1_r;
    ax2_r  <= abs_diff(rd_data[COORD_W-1:0], qx_r);
    ay2_r  <= abs_diff(rd_data[2*COORD_W-1:COORD_W], qy_r);
    az2_r  <= abs_diff(rd_data[3*COORD_W-1:2*COORD_W], qz_r);

    vld3_r <= vld2_r;
    idx3_r <= idx2_r;
    sx3_r  <= ax2_r * ax2_r;
    sy3_r  <= ay2_r * ay2_r;
    sz3_r  <= az2_r * az2_r;

    vld4_r <= vld3_r;
    idx4_r <= idx3_r;
    sum4_r <= DIST_W'(sx3_r) + DIST_W'(sy3_r) + DIST_W'(sz3_r);
  end

  assign take = p4_r && vld4_r && (!found_r || (sum4_r < best_r));

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      best_r     <= DIST_MAX;
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (take) begin
      best_r     <= sum4_r;
      best_idx_r <= idx4_r;
      found_r    <= 1'b1;
    end
  end

  always_comb begin
    status.scan_last  = cmd.scan_run && (cnt_r == IDX_W'(POINT_COUNT - 1));
    status.pipe_empty = !(p1_r || p2_r || p3_r || p4_r);
  end

  assign out_nearest_index = OUT_IDX_W'(best_idx_r);
  assign out_distance_sq   = best_r;
  assign out_found         = found_r;

endmodule

>>> rtl/nearest_point_search.sv
// Top level of the brute-force 3D nearest point search block.
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ----------------------------------------------
//  input     start, busy              in_opcode, in_slot, in_coord_x/y/z
//  result    out_valid (one cycle)    out_nearest_index, out_distance_sq, out_found
//
// A store transaction does not raise busy, which stays low after it.
// A query transaction keeps busy high while the scan reads one
// table entry per cycle from the point RAM's single read port, then a four-stage
// distance and minimum pipeline drains and the result is shown for one cycle.
// After reset the valid marks are clear and the block takes a transaction at once.
// The receiver cannot stall, so out_valid never waits.
module nearest_point_search (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_opcode,
  input  logic [npsrch_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [npsrch_pkg::COORD_W-1:0] in_coord_z,
  output logic                                  out_valid,
  output logic [npsrch_pkg::OUT_IDX_W-1:0]      out_nearest_index,
  output logic [npsrch_pkg::DIST_W-1:0]         out_distance_sq,
  output logic                                  out_found
);
  import npsrch_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  npsrch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_opcode(in_opcode),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  npsrch_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_slot          (in_slot),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .status           (status),
    .out_nearest_index(out_nearest_index),
    .out_distance_sq  (out_distance_sq),
    .out_found        (out_found)
  );

endmodule

>>> rtl/npsrch_checker.sv
// Port-level assertions for the nearest point search block and the bind that attaches them.
module npsrch_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_opcode,
  input logic                             out_valid,
  input logic [npsrch_pkg::OUT_IDX_W-1:0] out_nearest_index,
  input logic [npsrch_pkg::DIST_W-1:0]    out_distance_sq,
  input logic                             out_found
);
  import npsrch_pkg::*;

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_QUERY)) |=> busy)
    else $error("query transaction did not raise busy");

  a_store_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_STORE)) |=> (!busy && !out_valid))
    else $error("store transaction made the block busy or gave a result");

  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy ##1 (!busy && !out_valid)))
    else $error("result strobe not followed by idle");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_nearest_index == '0) && (out_distance_sq == DIST_MAX)))
    else $error("empty table result has wrong index or distance");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy) |-> !out_valid)
    else $error("result strobe while idle");

endmodule

bind nearest_point_search npsrch_checker u_npsrch_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_nearest_index(out_nearest_index),
  .out_distance_sq  (out_distance_sq),
  .out_found        (out_found)
);
